// File: sv/b32enc_pkg.sv
package b32enc_pkg;

  // Depth of the job queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned LevelW    = $clog2(FifoDepth + 1);

  // Symbol alphabet: letters for the low values, then digits from one.
  localparam logic [4:0] NumLetters = 5'd26;
  localparam logic [6:0] CharA      = 7'h41;
  localparam logic [6:0] CharOne    = 7'h31;

  // One job: up to three 5-bit symbols, most significant first.
  typedef struct packed {
    logic [14:0] syms;
    logic [1:0]  count;
    logic        eom;
  } job_t;

  // Queue status as seen by the front, the back and the checks.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [LevelW-1:0] level;
  } fifo_stat_t;

  // Maps a 5-bit symbol value onto its ASCII character.
  function automatic logic [6:0] to_ascii(input logic [4:0] v);
    logic [6:0] c;
    if (v < NumLetters) begin
      c = CharA + {2'b00, v};
    end else begin
      c = CharOne + {2'b00, v - NumLetters};
    end
    return c;
  endfunction

endpackage

// File: sv/b32enc_front.sv
module b32enc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output b32enc_pkg::job_t  job_o
);

  logic [3:0]  lb_q, lb_d;
  logic [2:0]  lc_q, lc_d;
  logic [11:0] bits;
  logic [3:0]  size;
  logic [3:0]  shamt;
  logic [14:0] aligned;
  logic        two_regular;
  logic [3:0]  rem_full;
  logic [2:0]  rem;
  logic        flush;
  logic [3:0]  rem_mask;

  // A byte is taken whenever the queue has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Join the pending bits with the new byte and left-align them in 15 bits,
  // so that each symbol, the zero-filled flush symbol too, is a fixed slice.
  assign bits        = {lb_q, data_byte_i};
  assign size        = {1'b0, lc_q} + 4'd8;
  assign shamt       = 4'd15 - size;
  assign aligned     = {3'b000, bits} << shamt;
  assign two_regular = (size >= 4'd10);
  assign rem_full    = size - (two_regular ? 4'd10 : 4'd5);
  assign rem         = rem_full[2:0];
  assign flush       = last_byte_i && (rem != 3'd0);
  assign rem_mask    = (4'b0001 << rem) - 4'b0001;

  // Classify the byte into a job for the back.
  always_comb begin
    job_o.syms  = aligned;
    job_o.count = (two_regular ? 2'd2 : 2'd1) + {1'b0, flush};
    job_o.eom   = last_byte_i;
  end

  // The bits left over after the byte, cleared at the end of a message.
  always_comb begin
    lb_d = lb_q;
    lc_d = lc_q;
    if (push_o) begin
      if (last_byte_i) begin
        lb_d = 4'd0;
        lc_d = 3'd0;
      end else begin
        lb_d = bits[3:0] & rem_mask;
        lc_d = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= 4'd0;
      lc_q <= 3'd0;
    end else begin
      lb_q <= lb_d;
      lc_q <= lc_d;
    end
  end

endmodule

// File: sv/b32enc_fifo.sv
module b32enc_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  b32enc_pkg::job_t        job_i,
  input  logic                    pop_i,
  output b32enc_pkg::job_t        head_o,
  output b32enc_pkg::fifo_stat_t  stat_o
);

  b32enc_pkg::job_t                    mem_q [b32enc_pkg::FifoDepth];
  logic [b32enc_pkg::PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [b32enc_pkg::PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [b32enc_pkg::LevelW-1:0]       level_q, level_d;

  // Status flags for both sides.
  always_comb begin
    stat_o.level = level_q;
    stat_o.empty = (level_q == '0);
    stat_o.full  = (level_q == b32enc_pkg::LevelW'(b32enc_pkg::FifoDepth));
  end

  assign head_o = mem_q[rd_ptr_q];

  // Pointer and level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Job storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: sv/b32enc_back.sv
module b32enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b32enc_pkg::job_t  head_i,
  input  logic              empty_i,
  input  logic              out_stall_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output logic [6:0]        symbol_char_o,
  output logic              end_of_message_o
);

  logic       valid_q, valid_d;
  logic [6:0] sym_q, sym_d;
  logic       eom_q, eom_d;
  logic [1:0] idx_q, idx_d;
  logic       slot_free;
  logic       load;
  logic       job_done;
  logic [4:0] cur;

  // The output register takes a new beat when it is empty or being taken.
  assign slot_free = !valid_q || !out_stall_i;
  assign load      = slot_free && !empty_i;
  assign job_done  = (idx_q == head_i.count - 2'd1);
  assign pop_o     = load && job_done;

  // Pick the current symbol of the head job.
  always_comb begin
    case (idx_q)
      2'd0:    cur = head_i.syms[14:10];
      2'd1:    cur = head_i.syms[9:5];
      default: cur = head_i.syms[4:0];
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    sym_d   = sym_q;
    eom_d   = eom_q;
    idx_d   = idx_q;
    if (slot_free) begin
      valid_d = load;
    end
    if (load) begin
      sym_d = b32enc_pkg::to_ascii(cur);
      eom_d = head_i.eom && job_done;
      idx_d = job_done ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Payload of the output beat.
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    eom_q <= eom_d;
  end

  assign out_valid_o      = valid_q;
  assign symbol_char_o    = sym_q;
  assign end_of_message_o = eom_q;

endmodule

// File: sv/base32_stream_encoder_core.sv
// Base32 stream encoder.
// Input channel: one raw byte per beat on data_byte_i, with last_byte_i set
// on the final byte of a message. Output channel: one ASCII symbol per beat
// on symbol_char_o ('A'..'Z', then '1'..'6'), with end_of_message_o set on
// the final symbol of a message. No padding symbols are produced.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// Each byte yields one or two symbols, plus a zero-filled flush symbol on a
// last byte that leaves bits over. The front classifies a byte in the cycle
// it arrives and places a job in a two-entry queue; the back sends one symbol
// per cycle, unless the receiver stalls, from a registered output stage. A
// byte's job passes through the queue into the output register. The single
// output port sets the pace; new bytes can queue while older ones are sent.
// Reset clears the pending bits, the queue and the output stage. When the
// receiver stalls, the output beat holds; the queue fills and in_stall_o
// rises once both entries are taken.
module base32_stream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] symbol_char_o,
  output logic       end_of_message_o
);

  b32enc_pkg::job_t       push_job;
  b32enc_pkg::job_t       head_job;
  b32enc_pkg::fifo_stat_t fifo_stat;
  logic                   push;
  logic                   pop;

  b32enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (fifo_stat.full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .job_o       (push_job)
  );

  b32enc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (fifo_stat)
  );

  b32enc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .empty_i          (fifo_stat.empty),
    .out_stall_i      (out_stall_i),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .symbol_char_o    (symbol_char_o),
    .end_of_message_o (end_of_message_o)
  );

  // The queue never overflows or underflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_stat.full))
    else $error("job queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fifo_stat.empty))
    else $error("job queue read while empty");

  // Every symbol sent belongs to the alphabet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((symbol_char_o >= 7'h41 && symbol_char_o <= 7'h5A) ||
                     (symbol_char_o >= 7'h31 && symbol_char_o <= 7'h36)))
    else $error("symbol outside the alphabet");

  // A pop without a push lowers the queue level by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (fifo_stat.level == $past(fifo_stat.level) - 1'b1))
    else $error("queue level wrong after a pop");

endmodule
